// ===== design/bpmse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool package
// Types and fixed widths shared by the pool cells and the top level.
// ----------------------------------------------------------------------------
package bpmse_pkg;

  // Fixed field widths of the stream payloads
  localparam int unsigned BLK_ID_W   = 16;
  localparam int unsigned BLK_SIZE_W = 13;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned EVICT_ID_W = 16;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 24;

  // Width of the running minimum; holds any size bound up to 65535
  localparam int unsigned BEST_W = 16;

  // Flags that ride with the search token along the chain
  typedef struct packed {
    logic valid;
    logic found;
  } bpmse_flag_t;

  // Control states: idle, or a search token sweeping the chain
  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } bpmse_state_e;

endpackage

// ===== design/block_pool_min_size_eviction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool with smallest-size eviction
// Fully associative tag pool of block ids and sizes, built as a chain of slot
// cells that a search token walks through one cell per cycle.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (lsb first)                         | beat
//  s_axis   | in  | block_id[15:0], block_size[28:16], pad           | one request
//  m_axis   | out | hit[0], slot[4:1], evicted[5], evicted_id[21:6]  | one result
//
//  Sweep: the token visits one cell per cycle; the slot write and result
//  capture happen once the token has passed the last cell.
//  One request is in the chain at a time; the next one enters after the write.
//  Reset: asynchronous, active low; clears state, fill level, token flags, output valids.
//  Stalls: the result sits in the output register and one holding stage, so a
//  new request is taken while a result waits; m_axis back-pressure only blocks
//  input once the holding stage is also full.
// ----------------------------------------------------------------------------
module block_pool_min_size_eviction #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned SIZE_BOUND = 4096,
  parameter int unsigned ID_WIDTH   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request: block_id[15:0], block_size[28:16], zeros[31:29]
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [bpmse_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // result: hit[0], slot[4:1], evicted[5], evicted_id[21:6], zeros[23:22]
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [bpmse_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(SLOTS);
  localparam logic [bpmse_pkg::BEST_W-1:0] BoundVal = bpmse_pkg::BEST_W'(SIZE_BOUND);

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  bpmse_pkg::bpmse_state_e state_q, state_d;

  logic                             accept;
  logic                             done;
  logic                             out_free;
  logic [CntW-1:0]                  count_q, count_d;
  logic [bpmse_pkg::BLK_SIZE_W-1:0] req_size_q;
  logic [ID_WIDTH-1:0]              req_id;

  // chain taps, index k is the input of cell k
  bpmse_pkg::bpmse_flag_t        ch_flag      [SLOTS+1];
  logic [ID_WIDTH-1:0]           ch_id        [SLOTS+1];
  logic [IdxW-1:0]               ch_hit_idx   [SLOTS+1];
  logic [bpmse_pkg::BEST_W-1:0]  ch_best_size [SLOTS+1];
  logic [IdxW-1:0]               ch_best_idx  [SLOTS+1];
  logic [ID_WIDTH-1:0]           ch_best_id   [SLOTS+1];
  logic [SLOTS-1:0]              tok_live;

  // slot update
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;

  // outcome of the finished sweep
  logic                              res_hit;
  logic [bpmse_pkg::SLOT_W-1:0]      res_slot;
  logic                              res_evicted;
  logic [bpmse_pkg::EVICT_ID_W-1:0]  res_evicted_id;

  // output register and holding stage
  logic                              m_valid_q;
  logic [bpmse_pkg::OUT_DATA_W-1:0]  m_data_q;
  logic                              pend_valid_q;
  logic [bpmse_pkg::OUT_DATA_W-1:0]  pend_data_q;
  logic [bpmse_pkg::OUT_DATA_W-1:0]  res_data;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign done     = ch_flag[SLOTS].valid;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign req_id   = ID_WIDTH'(s_axis_tdata_i[bpmse_pkg::BLK_ID_W-1:0]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpmse_pkg::ST_IDLE:  if (accept) state_d = bpmse_pkg::ST_SWEEP;
      bpmse_pkg::ST_SWEEP: if (done)   state_d = bpmse_pkg::ST_IDLE;
      default:             state_d = bpmse_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      bpmse_pkg::ST_IDLE:  s_axis_tready_o = !pend_valid_q;
      bpmse_pkg::ST_SWEEP: s_axis_tready_o = 1'b0;
      default:             s_axis_tready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpmse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Token injection: a fresh search enters cell 0 on the accepting edge
  // --------------------------------------------------------------------------
  assign ch_flag[0].valid = accept;
  assign ch_flag[0].found = 1'b0;
  assign ch_id[0]         = req_id;
  assign ch_hit_idx[0]    = '0;
  assign ch_best_size[0]  = BoundVal;   // only sizes below the bound qualify
  assign ch_best_idx[0]   = '0;         // default victim is slot 0
  assign ch_best_id[0]    = '0;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_size_q <= s_axis_tdata_i[bpmse_pkg::BLK_ID_W +: bpmse_pkg::BLK_SIZE_W];
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    bpmse_cell #(
      .SLOTS    (SLOTS),
      .ID_WIDTH (ID_WIDTH),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .count_i     (count_q),
      .wr_en_i     (wr_en),
      .wr_idx_i    (wr_idx),
      .wr_id_i     (ch_id[SLOTS]),
      .wr_size_i   (req_size_q),
      .flag_i      (ch_flag[k]),
      .id_i        (ch_id[k]),
      .hit_idx_i   (ch_hit_idx[k]),
      .best_size_i (ch_best_size[k]),
      .best_idx_i  (ch_best_idx[k]),
      .best_id_i   (ch_best_id[k]),
      .flag_o      (ch_flag[k+1]),
      .id_o        (ch_id[k+1]),
      .hit_idx_o   (ch_hit_idx[k+1]),
      .best_size_o (ch_best_size[k+1]),
      .best_idx_o  (ch_best_idx[k+1]),
      .best_id_o   (ch_best_id[k+1])
    );
    assign tok_live[k] = ch_flag[k+1].valid;
  end

  // --------------------------------------------------------------------------
  // Outcome at the chain end: hit, fill the next free slot, or evict
  // --------------------------------------------------------------------------
  always_comb begin
    wr_en          = 1'b0;
    wr_idx         = '0;
    count_d        = count_q;
    res_hit        = 1'b0;
    res_slot       = '0;
    res_evicted    = 1'b0;
    res_evicted_id = '0;
    priority if (ch_flag[SLOTS].found) begin
      res_hit  = 1'b1;
      res_slot = bpmse_pkg::SLOT_W'(ch_hit_idx[SLOTS]);
    end else if (count_q != FullCnt) begin
      wr_en    = done;
      wr_idx   = count_q[IdxW-1:0];
      res_slot = bpmse_pkg::SLOT_W'(count_q[IdxW-1:0]);
      if (done) begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      wr_en          = done;
      wr_idx         = ch_best_idx[SLOTS];
      res_slot       = bpmse_pkg::SLOT_W'(ch_best_idx[SLOTS]);
      res_evicted    = 1'b1;
      res_evicted_id = bpmse_pkg::EVICT_ID_W'(ch_best_id[SLOTS]);
    end
  end

  assign res_data = {2'b00, res_evicted_id, res_evicted, res_slot, res_hit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register with one holding stage behind it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q    <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      priority if (done && out_free) begin
        m_valid_q <= 1'b1;
      end else if (done) begin
        pend_valid_q <= 1'b1;
      end else if (pend_valid_q && out_free) begin
        m_valid_q    <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (done && out_free) begin
      m_data_q <= res_data;
    end else if (done) begin
      pend_data_q <= res_data;
    end else if (pend_valid_q && out_free) begin
      m_data_q <= pend_data_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  // at most one search token anywhere in the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_live))
    else $error("more than one search token in the cell chain");

  // fill level never passes the pool size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("fill level beyond pool size");

  // holding stage only used behind a full output register
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> m_valid_q)
    else $error("holding stage full while output register empty");

  // a finishing sweep always finds room for its result
  a_done_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !pend_valid_q)
    else $error("result finished with holding stage occupied");

  // no new request while a sweep is running
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_live != '0) |-> !accept)
    else $error("request accepted during a sweep");
`endif

endmodule

// ===== design/bpmse_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool cell
// Holds one slot (id, size), checks the passing search token against it and
// registers the updated token for the next cell.
// ----------------------------------------------------------------------------
module bpmse_cell #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned ID_WIDTH = 16,
  parameter int unsigned CELL_IDX = 0,
  localparam int unsigned IdxW    = $clog2(SLOTS),
  localparam int unsigned CntW    = $clog2(SLOTS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // fill level and slot write
  input  logic [CntW-1:0]               count_i,
  input  logic                          wr_en_i,
  input  logic [IdxW-1:0]               wr_idx_i,
  input  logic [ID_WIDTH-1:0]           wr_id_i,
  input  logic [bpmse_pkg::BLK_SIZE_W-1:0] wr_size_i,
  // token from the previous cell
  input  bpmse_pkg::bpmse_flag_t        flag_i,
  input  logic [ID_WIDTH-1:0]           id_i,
  input  logic [IdxW-1:0]               hit_idx_i,
  input  logic [bpmse_pkg::BEST_W-1:0]  best_size_i,
  input  logic [IdxW-1:0]               best_idx_i,
  input  logic [ID_WIDTH-1:0]           best_id_i,
  // token to the next cell
  output bpmse_pkg::bpmse_flag_t        flag_o,
  output logic [ID_WIDTH-1:0]           id_o,
  output logic [IdxW-1:0]               hit_idx_o,
  output logic [bpmse_pkg::BEST_W-1:0]  best_size_o,
  output logic [IdxW-1:0]               best_idx_o,
  output logic [ID_WIDTH-1:0]           best_id_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);
  localparam logic [CntW-1:0] MyCnt = CntW'(CELL_IDX);

  logic [ID_WIDTH-1:0]              slot_id_q;
  logic [bpmse_pkg::BLK_SIZE_W-1:0] slot_size_q;

  logic                          filled;
  logic                          match;
  logic                          smaller;
  bpmse_pkg::bpmse_flag_t        flag_d, flag_q;
  logic [IdxW-1:0]               hit_idx_d, hit_idx_q;
  logic [bpmse_pkg::BEST_W-1:0]  best_size_d, best_size_q;
  logic [IdxW-1:0]               best_idx_d, best_idx_q;
  logic [ID_WIDTH-1:0]           best_id_d, best_id_q;
  logic [ID_WIDTH-1:0]           id_q;

  assign filled  = (MyCnt < count_i);
  assign match   = filled && (slot_id_q == id_i);
  assign smaller = filled &&
                   ({{(bpmse_pkg::BEST_W - bpmse_pkg::BLK_SIZE_W){1'b0}}, slot_size_q}
                    < best_size_i);

  always_comb begin
    flag_d      = flag_i;
    hit_idx_d   = hit_idx_i;
    best_size_d = best_size_i;
    best_idx_d  = best_idx_i;
    best_id_d   = best_id_i;
    // first match wins
    if (!flag_i.found && match) begin
      flag_d.found = 1'b1;
      hit_idx_d    = MyIdx;
    end
    // slot 0 is the fallback victim, so its id rides along by default
    if (CELL_IDX == 0) begin
      best_id_d = slot_id_q;
    end
    // strict compare keeps the lowest slot on a tie
    if (smaller) begin
      best_size_d = {{(bpmse_pkg::BEST_W - bpmse_pkg::BLK_SIZE_W){1'b0}}, slot_size_q};
      best_idx_d  = MyIdx;
      best_id_d   = slot_id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
    end else begin
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q        <= id_i;
    hit_idx_q   <= hit_idx_d;
    best_size_q <= best_size_d;
    best_idx_q  <= best_idx_d;
    best_id_q   <= best_id_d;
    if (wr_en_i && (wr_idx_i == MyIdx)) begin
      slot_id_q   <= wr_id_i;
      slot_size_q <= wr_size_i;
    end
  end

  assign flag_o      = flag_q;
  assign id_o        = id_q;
  assign hit_idx_o   = hit_idx_q;
  assign best_size_o = best_size_q;
  assign best_idx_o  = best_idx_q;
  assign best_id_o   = best_id_q;

endmodule
